// ===== rtl/dependency_aware_task_dispatcher_assert.svh =====
// assertion macros for the checker file
`ifndef DEPENDENCY_AWARE_TASK_DISPATCHER_ASSERT_SVH
`define DEPENDENCY_AWARE_TASK_DISPATCHER_ASSERT_SVH
// property a implies property b in the same cycle
`define DTD_ASSERT_IMP(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
// property a implies property b in the next cycle
`define DTD_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
`endif

// ===== rtl/datd_pkg.sv =====
// ----------------------------------------------------------------------------
// datd_pkg
// shared types and codes of the task dispatcher
// ----------------------------------------------------------------------------
package datd_pkg;
   localparam int ID_BITS = 32;

   typedef enum logic [1:0] {
      FUNC_ENQ  = 2'd0,
      FUNC_DISP = 2'd1,
      FUNC_FIN  = 2'd2,
      FUNC_NOP  = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_NONE     = 3'd1,
      ST_QFULL    = 3'd2,
      ST_PFULL    = 3'd3,
      ST_NOTPEND  = 3'd4
   } status_type;

   // control from the sequencer to every queue cell
   typedef struct packed {
      logic shift;   // rotate one position toward the back
      logic push;    // load the incoming item into the front
   } qctl_type;
endpackage

// ===== rtl/dependency_aware_task_dispatcher.sv =====
// dispatch examines the back entry and rotates the ring of cells one place per entry:
// each entry's dependency is checked by a scan of the pending set, for up to N entries
// in turn (N queued entries, QUEUE_DEPTH at most)
// enqueue and finish each scan the whole pending set
// one item at a time; the next item is taken in the cycle after a result is loaded
// synchronous reset empties the queue and the pending set, id counter to 0
// ----------------------------------------------------------------------------
// dependency_aware_task_dispatcher
// task queue with single-dependency gating and a pending-id set
// ----------------------------------------------------------------------------
module dependency_aware_task_dispatcher #(
   parameter int QUEUE_DEPTH   = 32,
   parameter int PENDING_DEPTH = 64,
   parameter int TAG_BITS      = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_func,
   input  logic [31:0]           req_dep_id,
   input  logic [15:0]           req_task_tag,
   input  logic [31:0]           req_done_id,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [2:0]            rsp_status,
   output logic [31:0]           rsp_task_id,
   output logic [15:0]           rsp_out_tag
);
   import datd_pkg::*;
   localparam int QW = $clog2(QUEUE_DEPTH + 1);
   localparam int PW = $clog2(PENDING_DEPTH);
   localparam int PC = $clog2(PENDING_DEPTH + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_PSCAN, S_ENQ, S_DCHK, S_DSCAN, S_DROT, S_RESP
   } state_type;

   state_type          state_ff;
   func_type           func_ff;
   logic [31:0]        dep_ff, key_ff, ctr_ff;
   logic [TAG_BITS-1:0] tag_ff;
   logic [QW-1:0]      count_ff, exam_ff, left_ff;
   logic [PC-1:0]      pidx_ff;
   logic               found_ff, free_ok_ff;
   logic [PW-1:0]      hit_ff, free_ff;
   logic [2:0]         st_ff;
   logic [31:0]        oid_ff;
   logic [15:0]        otag_ff;
   logic               rv_ff;
   logic [2:0]         rsp_st_ff;
   logic [31:0]        rsp_id_ff;
   logic [15:0]        rsp_tag_ff;

   // pending set: id memory plus valid flags
   logic [31:0]              pmem [PENDING_DEPTH];
   logic [31:0]              prd_ff;
   logic [PENDING_DEPTH-1:0] pval_ff;
   logic                     pwe;
   logic [PW-1:0]            pwa, pra;
   logic                     pval_rd_ff;

   // queue cells: index 0 is the back
   logic [31:0]         cid [QUEUE_DEPTH];
   logic [31:0]         cdep [QUEUE_DEPTH];
   logic [TAG_BITS-1:0] ctag [QUEUE_DEPTH];
   qctl_type            qctl;
   logic [31:0]         nid;
   logic                shift_all;

   assign nid = (ctr_ff == 32'hFFFF_FFFF) ? 32'd1 : ctr_ff + 32'd1;

   // rotation: all cells below count take neighbor above; top valid takes back
   genvar g;
   generate
      for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
         logic [31:0]         nb_i, nb_d;
         logic [TAG_BITS-1:0] nb_t;
         logic                inrange, istop;
         qctl_type            c;
         assign inrange = (QW'(g) < count_ff);
         assign istop   = (QW'(g) == count_ff - QW'(1));
         if (g == QUEUE_DEPTH - 1) begin : g_last
            assign nb_i = cid[0];
            assign nb_d = cdep[0];
            assign nb_t = ctag[0];
         end else begin : g_mid
            assign nb_i = istop ? cid[0]  : cid[g+1];
            assign nb_d = istop ? cdep[0] : cdep[g+1];
            assign nb_t = istop ? ctag[0] : ctag[g+1];
         end
         assign c.shift = shift_all && inrange;
         assign c.push  = qctl.push;
         datd_qcell #(.TAG_W(TAG_BITS)) u_cell (
            .clock(clock), .ctl(c), .load_sel(QW'(g) == count_ff),
            .nb_id(nb_i), .nb_dep(nb_d), .nb_tag(nb_t),
            .new_id(nid), .new_dep(dep_ff), .new_tag(tag_ff),
            .id_q(cid[g]), .dep_q(cdep[g]), .tag_q(ctag[g])
         );
      end
   endgenerate

   assign pra = pidx_ff[PW-1:0];
   always_ff @(posedge clock) begin
      if (pwe) pmem[pwa] <= nid;
      prd_ff     <= pmem[pra];
      pval_rd_ff <= pval_ff[pra];
   end

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rv_ff;
   assign rsp_status  = rsp_st_ff;
   assign rsp_task_id = rsp_id_ff;
   assign rsp_out_tag = rsp_tag_ff;

   // scan index in previous cycle produced prd_ff; pidx_ff-1 is its slot
   logic [PW-1:0] prev_slot;
   logic          rd_hit;
   assign prev_slot = PW'(pidx_ff - PC'(1));
   assign rd_hit    = pval_rd_ff && (prd_ff == key_ff) && (pidx_ff != '0);

   always_comb begin
      qctl.push  = (state_ff == S_ENQ) && !found_ff && free_ok_ff
                   || (state_ff == S_ENQ) && found_ff;
      qctl.shift = 1'b0;
      shift_all  = (state_ff == S_DROT);
      pwe        = (state_ff == S_ENQ) && !found_ff && free_ok_ff
                   && (count_ff < QW'(QUEUE_DEPTH));
      pwa        = free_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         ctr_ff     <= '0;
         pval_ff    <= '0;
         rv_ff      <= 1'b0;
         rsp_st_ff  <= '0;
         rsp_id_ff  <= '0;
         rsp_tag_ff <= '0;
      end else begin
         // the result register is only reloaded from the response state
         if (rv_ff && rsp_ready && state_ff != S_RESP) rv_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  func_ff    <= func_type'(req_func);
                  dep_ff     <= req_dep_id;
                  tag_ff     <= req_task_tag[TAG_BITS-1:0];
                  pidx_ff    <= '0;
                  found_ff   <= 1'b0;
                  free_ok_ff <= 1'b0;
                  oid_ff     <= '0;
                  otag_ff    <= '0;
                  priority case (func_type'(req_func))
                     FUNC_ENQ: begin
                        if (count_ff >= QW'(QUEUE_DEPTH)) begin
                           st_ff    <= ST_QFULL;
                           state_ff <= S_RESP;
                        end else begin
                           st_ff    <= ST_OK;
                           key_ff   <= (ctr_ff == 32'hFFFF_FFFF) ? 32'd1
                                       : ctr_ff + 32'd1;
                           state_ff <= S_PSCAN;
                        end
                     end
                     FUNC_FIN: begin
                        st_ff    <= ST_OK;
                        key_ff   <= req_done_id;
                        state_ff <= S_PSCAN;
                     end
                     FUNC_DISP: begin
                        exam_ff  <= '0;
                        left_ff  <= count_ff;
                        state_ff <= (count_ff == '0) ? S_RESP : S_DCHK;
                        st_ff    <= (count_ff == '0) ? ST_NONE : ST_OK;
                     end
                     default: begin
                        st_ff    <= ST_OK;
                        state_ff <= S_RESP;
                     end
                  endcase
               end
            end
            S_PSCAN: begin
               // one slot a cycle, read data is registered
               if (pidx_ff != '0) begin
                  if (rd_hit && !found_ff) begin
                     found_ff <= 1'b1;
                     hit_ff   <= prev_slot;
                  end
                  if (!pval_rd_ff && !free_ok_ff) begin
                     free_ok_ff <= 1'b1;
                     free_ff    <= prev_slot;
                  end
               end
               if (pidx_ff == PC'(PENDING_DEPTH)) begin
                  if (func_ff == FUNC_FIN) begin
                     if (rd_hit || found_ff) begin
                        pval_ff[found_ff ? hit_ff : prev_slot] <= 1'b0;
                     end else st_ff <= ST_NOTPEND;
                     state_ff <= S_RESP;
                  end else begin
                     state_ff <= S_ENQ;
                  end
               end else pidx_ff <= pidx_ff + PC'(1);
            end
            S_ENQ: begin
               if (found_ff || free_ok_ff) begin
                  if (!found_ff) pval_ff[free_ff] <= 1'b1;
                  ctr_ff   <= nid;
                  oid_ff   <= nid;
                  count_ff <= count_ff + QW'(1);
               end else st_ff <= ST_PFULL;
               state_ff <= S_RESP;
            end
            S_DCHK: begin
               // look up the back entry's dependency
               key_ff     <= cdep[0];
               pidx_ff    <= '0;
               found_ff   <= 1'b0;
               state_ff   <= S_DSCAN;
            end
            S_DSCAN: begin
               if (rd_hit) found_ff <= 1'b1;
               if (pidx_ff == PC'(PENDING_DEPTH)) begin
                  if (!(found_ff || rd_hit) || key_ff == '0) begin
                     // ready: take back entry and rotate it out
                     oid_ff   <= cid[0];
                     otag_ff  <= 16'(ctag[0]);
                     state_ff <= S_DROT;
                     left_ff  <= '0;
                  end else begin
                     exam_ff  <= exam_ff + QW'(1);
                     left_ff  <= left_ff - QW'(1);
                     state_ff <= S_DROT;
                  end
               end else pidx_ff <= pidx_ff + PC'(1);
            end
            S_DROT: begin
               if (left_ff == '0 && exam_ff != count_ff) begin
                  // after the rotation the taken entry sits at the top
                  count_ff <= count_ff - QW'(1);
                  state_ff <= S_RESP;
               end else if (left_ff == '0) begin
                  st_ff    <= ST_NONE;
                  state_ff <= S_RESP;
               end else state_ff <= S_DCHK;
            end
            S_RESP: begin
               if (!rv_ff || rsp_ready) begin
                  rsp_st_ff  <= st_ff;
                  rsp_id_ff  <= (st_ff == ST_OK) ? oid_ff : '0;
                  rsp_tag_ff <= (st_ff == ST_OK) ? otag_ff : '0;
                  rv_ff      <= 1'b1;
                  state_ff   <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ===== rtl/datd_qcell.sv =====
// ----------------------------------------------------------------------------
// datd_qcell
// one queue position: holds an entry, loads a new one on push and takes its neighbor's on shift
// ----------------------------------------------------------------------------
module datd_qcell #(
   parameter int TAG_W = 16
) (
   input  logic                       clock,
   input  datd_pkg::qctl_type         ctl,
   input  logic                       load_sel,
   input  logic [datd_pkg::ID_BITS-1:0] nb_id,
   input  logic [datd_pkg::ID_BITS-1:0] nb_dep,
   input  logic [TAG_W-1:0]           nb_tag,
   input  logic [datd_pkg::ID_BITS-1:0] new_id,
   input  logic [datd_pkg::ID_BITS-1:0] new_dep,
   input  logic [TAG_W-1:0]           new_tag,
   output logic [datd_pkg::ID_BITS-1:0] id_q,
   output logic [datd_pkg::ID_BITS-1:0] dep_q,
   output logic [TAG_W-1:0]           tag_q
);
   import datd_pkg::*;
   logic [ID_BITS-1:0] id_ff, dep_ff;
   logic [TAG_W-1:0]   tag_ff;

   always_ff @(posedge clock) begin
      if (ctl.push && load_sel) begin
         id_ff  <= new_id;
         dep_ff <= new_dep;
         tag_ff <= new_tag;
      end else if (ctl.shift) begin
         id_ff  <= nb_id;
         dep_ff <= nb_dep;
         tag_ff <= nb_tag;
      end
   end
   assign id_q  = id_ff;
   assign dep_q = dep_ff;
   assign tag_q = tag_ff;
endmodule

// ===== rtl/datd_checker.sv =====
// ----------------------------------------------------------------------------
// datd_checker
// port-level checks of the task dispatcher
// ----------------------------------------------------------------------------
`include "dependency_aware_task_dispatcher_assert.svh"
module datd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic [31:0] rsp_task_id,
   input logic [15:0] rsp_out_tag
);
   `DTD_ASSERT_IMP(a_stat_range, clock, reset, rsp_valid, rsp_status <= 3'd4)
   `DTD_ASSERT_IMP(a_err_zero, clock, reset, rsp_valid && rsp_status != 3'd0,
      rsp_task_id == 32'd0 && rsp_out_tag == 16'd0)
   `DTD_ASSERT_NEXT(a_one_at_time, clock, reset, req_valid && req_ready,
      !req_ready)
   `DTD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_task_id))
endmodule

bind dependency_aware_task_dispatcher datd_checker u_datd_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
   .rsp_task_id(rsp_task_id), .rsp_out_tag(rsp_out_tag)
);
